// ===== hdl/gntl_pkg.sv =====
// Shared constants, register codes, sequencer states and types for the track association block.
package gntl_pkg;

  localparam int DEF_MAX_TRACKED = 64;
  localparam int DEF_COORD_BITS  = 16;

  localparam int GATE_W    = 16;
  localparam int ID_W      = 32;
  localparam int AGE_W     = 16;
  localparam int MISS_W    = 8;
  localparam int THR_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int SQ_W      = 2 * GATE_W;
  localparam int SUM_W     = SQ_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_DIST        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MISSING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OBSERVATIONS = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OBS_SCAN,
    ST_OBS_DRAIN,
    ST_OBS_READ,
    ST_OBS_FETCH,
    ST_OBS_STORE,
    ST_OBS_MARK,
    ST_EOF_SCAN,
    ST_EOF_DRAIN,
    ST_DONE
  } state_t;

  // ok: eligible on the way in, within the gate on the way out
  typedef struct packed {
    logic vld;
    logic ok;
  } dist_ctl_t;

endpackage

// ===== hdl/gntl_dist.sv =====
// Three-stage squared-distance and gating pipeline for one table entry per cycle.
module gntl_dist #(
  parameter int COORD_BITS = gntl_pkg::DEF_COORD_BITS,
  parameter int IW         = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gntl_pkg::dist_ctl_t               in_ctl,
  input  logic [IW-1:0]                     in_idx,
  input  logic signed [COORD_BITS-1:0]      obs_x,
  input  logic signed [COORD_BITS-1:0]      obs_y,
  input  logic signed [COORD_BITS-1:0]      obs_z,
  input  logic signed [COORD_BITS-1:0]      ent_x,
  input  logic signed [COORD_BITS-1:0]      ent_y,
  input  logic signed [COORD_BITS-1:0]      ent_z,
  input  logic [gntl_pkg::GATE_W-1:0]       gate,
  input  logic [gntl_pkg::SQ_W-1:0]         gate_sq,
  output gntl_pkg::dist_ctl_t               out_ctl,
  output logic [IW-1:0]                     out_idx,
  output logic [gntl_pkg::SUM_W-1:0]        out_dist,
  output logic                              busy
);

  localparam int DW    = COORD_BITS + 1;
  localparam int CMP_W = (DW > gntl_pkg::GATE_W) ? DW : gntl_pkg::GATE_W;

  function automatic logic [DW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                             input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  logic [DW-1:0] dx, dy, dz;
  logic          in_gate;

  gntl_pkg::dist_ctl_t           s1_ctl, s2_ctl;
  logic [IW-1:0]                 s1_idx, s2_idx;
  logic [gntl_pkg::GATE_W-1:0]   s1_dx, s1_dy, s1_dz;
  logic [gntl_pkg::SQ_W-1:0]     s2_sx, s2_sy, s2_sz;
  logic [gntl_pkg::SUM_W-1:0]    sum;

  always_comb begin
    dx = abs_diff(obs_x, ent_x);
    dy = abs_diff(obs_y, ent_y);
    dz = abs_diff(obs_z, ent_z);
    in_gate = (CMP_W'(dx) <= CMP_W'(gate)) && (CMP_W'(dy) <= CMP_W'(gate)) &&
              (CMP_W'(dz) <= CMP_W'(gate));
    sum = gntl_pkg::SUM_W'(s2_sx) + gntl_pkg::SUM_W'(s2_sy) + gntl_pkg::SUM_W'(s2_sz);
  end

  // inside the gate each difference fits the gate width
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      s2_ctl  <= '0;
      out_ctl <= '0;
    end else begin
      s1_ctl.vld  <= in_ctl.vld;
      s1_ctl.ok   <= in_ctl.ok && in_gate;
      s2_ctl      <= s1_ctl;
      out_ctl.vld <= s2_ctl.vld;
      out_ctl.ok  <= s2_ctl.ok && (sum <= gntl_pkg::SUM_W'(gate_sq));
    end
    s1_idx   <= in_idx;
    s1_dx    <= gntl_pkg::GATE_W'(dx);
    s1_dy    <= gntl_pkg::GATE_W'(dy);
    s1_dz    <= gntl_pkg::GATE_W'(dz);
    s2_idx   <= s1_idx;
    s2_sx    <= s1_dx * s1_dx;
    s2_sy    <= s1_dy * s1_dy;
    s2_sz    <= s1_dz * s1_dz;
    out_idx  <= s2_idx;
    out_dist <= sum;
  end

  assign busy = s1_ctl.vld || s2_ctl.vld || out_ctl.vld;

endmodule

// ===== hdl/gated_nearest_track_lifecycle.sv =====
// Top level: gated nearest-neighbour track association with track lifecycle.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | op, center_x, center_y, center_z
//  out     | out_valid/ out_ready | cluster_id, cluster_age, cluster_status,
//          |                      | first_seen_frame, was_matched, table_full,
//          |                      | tracked_count, dropped_count
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data (always ready)
//
// One item at a time. The old bank is streamed out of the entry memory one
// entry a cycle into a three-stage distance pipe, then the best match is read
// back and the new entry (and the used mark) are written through the single
// write port. End of frame streams the old bank out of the entry memory one entry a cycle.
// The next item is taken only in the idle state, after the result is loaded.
// Reset is synchronous; no clearing pass, only entries below the counts are read.
// The result sits in an output register; a stalled output holds the sequencer
// in its final state until the slot frees.
module gated_nearest_track_lifecycle #(
  parameter int MAX_TRACKED = gntl_pkg::DEF_MAX_TRACKED,
  parameter int COORD_BITS  = gntl_pkg::DEF_COORD_BITS,
  localparam int CW         = $clog2(MAX_TRACKED + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [COORD_BITS-1:0]         center_x,
  input  logic signed [COORD_BITS-1:0]         center_y,
  input  logic signed [COORD_BITS-1:0]         center_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gntl_pkg::ID_W-1:0]            cluster_id,
  output logic [gntl_pkg::AGE_W-1:0]           cluster_age,
  output logic                                 cluster_status,
  output logic [gntl_pkg::ID_W-1:0]            first_seen_frame,
  output logic                                 was_matched,
  output logic                                 table_full,
  output logic [CW-1:0]                        tracked_count,
  output logic [CW-1:0]                        dropped_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gntl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gntl_pkg::CFG_DAT_W-1:0]       cfg_data
);

  localparam int IW    = $clog2(MAX_TRACKED);
  localparam int AW    = $clog2(2 * MAX_TRACKED);
  localparam int ID_W  = gntl_pkg::ID_W;
  localparam int AGE_W = gntl_pkg::AGE_W;
  localparam int MS_W  = gntl_pkg::MISS_W;
  localparam int REC_W = 1 + 3 * COORD_BITS + 2 * ID_W + AGE_W + MS_W;

  // config registers
  logic [gntl_pkg::GATE_W-1:0] gate_dist;
  logic [MS_W-1:0]             max_missing;
  logic [gntl_pkg::THR_W-1:0]  min_observations;

  gntl_pkg::state_t st, st_next;

  // item and lifecycle state
  logic                           op_eof;
  logic signed [COORD_BITS-1:0]   ox, oy, oz;
  logic [gntl_pkg::SQ_W-1:0]      gate_sq;
  logic [CW-1:0]                  scan_i, old_count, new_count, dropped;
  logic                           bank;
  logic [ID_W-1:0]                next_ident, frame_number;
  logic                           found;
  logic [IW-1:0]                  best_idx;
  logic [gntl_pkg::SUM_W-1:0]     best_dist;
  logic [ID_W-1:0]                res_id, res_first;
  logic [AGE_W-1:0]               res_age;
  logic                           res_full;
  logic [REC_W-1:0]               hold_rec;

  // entry memory: both banks, record {used, x, y, z, id, first, age, missed}
  logic [REC_W-1:0] mem [2*MAX_TRACKED];
  logic [REC_W-1:0] rdata, wdata;
  logic [AW-1:0]    raddr, waddr, old_base, new_base;
  logic             rd_en, we, rd_v;
  logic [IW-1:0]    rd_idx;

  logic                         r_used;
  logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
  logic [ID_W-1:0]              r_id, r_first;
  logic [AGE_W-1:0]             r_age;
  logic [MS_W-1:0]              r_missed, miss_inc;

  logic full, eof_keep, eof_drop, out_load, drain_done;
  logic [gntl_pkg::THR_W-1:0] thr;

  gntl_pkg::dist_ctl_t        d_in, d_out;
  logic [IW-1:0]              d_idx;
  logic [gntl_pkg::SUM_W-1:0] d_dist;
  logic                       d_busy;

  assign {r_used, r_x, r_y, r_z, r_id, r_first, r_age, r_missed} = rdata;

  assign cfg_ready = 1'b1;
  assign old_base  = bank ? AW'(MAX_TRACKED) : '0;
  assign new_base  = bank ? '0 : AW'(MAX_TRACKED);
  assign full      = (new_count == CW'(MAX_TRACKED));
  assign miss_inc  = (r_missed == '1) ? r_missed : r_missed + 1'b1;
  assign eof_keep  = op_eof && rd_v && !r_used && (miss_inc <= max_missing) && !full;
  assign eof_drop  = op_eof && rd_v && !r_used && !eof_keep;
  assign thr       = (min_observations == '0) ? gntl_pkg::THR_W'(1) : min_observations;
  assign drain_done = !rd_v && !d_busy;

  // stale entries (missed above the limit) never match
  assign d_in.vld = rd_v && !op_eof;
  assign d_in.ok  = !r_used && (r_missed <= max_missing);

  gntl_dist #(
    .COORD_BITS (COORD_BITS),
    .IW         (IW)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (d_in),
    .in_idx   (rd_idx),
    .obs_x    (ox),
    .obs_y    (oy),
    .obs_z    (oz),
    .ent_x    (r_x),
    .ent_y    (r_y),
    .ent_z    (r_z),
    .gate     (gate_dist),
    .gate_sq  (gate_sq),
    .out_ctl  (d_out),
    .out_idx  (d_idx),
    .out_dist (d_dist),
    .busy     (d_busy)
  );

  // sequencer
  always_comb begin
    st_next  = st;
    rd_en    = 1'b0;
    raddr    = old_base + AW'(scan_i[IW-1:0]);
    out_load = 1'b0;
    in_ready = (st == gntl_pkg::ST_IDLE);
    unique case (st)
      gntl_pkg::ST_IDLE: begin
        if (in_valid) st_next = op ? gntl_pkg::ST_EOF_SCAN : gntl_pkg::ST_OBS_SCAN;
      end
      gntl_pkg::ST_OBS_SCAN: begin
        if (scan_i < old_count) rd_en = 1'b1;
        else st_next = gntl_pkg::ST_OBS_DRAIN;
      end
      gntl_pkg::ST_OBS_DRAIN: begin
        if (drain_done) st_next = found ? gntl_pkg::ST_OBS_READ : gntl_pkg::ST_OBS_STORE;
      end
      gntl_pkg::ST_OBS_READ: begin
        rd_en   = 1'b1;
        raddr   = old_base + AW'(best_idx);
        st_next = gntl_pkg::ST_OBS_FETCH;
      end
      gntl_pkg::ST_OBS_FETCH: st_next = gntl_pkg::ST_OBS_STORE;
      gntl_pkg::ST_OBS_STORE: begin
        st_next = (found && !full) ? gntl_pkg::ST_OBS_MARK : gntl_pkg::ST_DONE;
      end
      gntl_pkg::ST_OBS_MARK: st_next = gntl_pkg::ST_DONE;
      gntl_pkg::ST_EOF_SCAN: begin
        if (scan_i < old_count) rd_en = 1'b1;
        else st_next = gntl_pkg::ST_EOF_DRAIN;
      end
      gntl_pkg::ST_EOF_DRAIN: begin
        if (!rd_v) st_next = gntl_pkg::ST_DONE;
      end
      gntl_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          st_next  = gntl_pkg::ST_IDLE;
        end
      end
      default: st_next = gntl_pkg::ST_IDLE;
    endcase
  end

  // single write port: new entry, used mark, or survivor copy
  always_comb begin
    we    = 1'b0;
    waddr = new_base + AW'(new_count[IW-1:0]);
    wdata = {1'b0, ox, oy, oz, res_id, res_first, res_age, MS_W'(0)};
    if (st == gntl_pkg::ST_OBS_STORE) begin
      we = !full;
    end else if (st == gntl_pkg::ST_OBS_MARK) begin
      we    = 1'b1;
      waddr = old_base + AW'(best_idx);
      wdata = {1'b1, hold_rec[REC_W-2:0]};
    end else if (eof_keep) begin
      we    = 1'b1;
      wdata = {1'b0, r_x, r_y, r_z, r_id, r_first, r_age, miss_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= gntl_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_dist        <= gntl_pkg::GATE_W'(100);
      max_missing      <= MS_W'(3);
      min_observations <= gntl_pkg::THR_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gntl_pkg::REG_GATE_DIST:        gate_dist        <= cfg_data;
        gntl_pkg::REG_MAX_MISSING:      max_missing      <= cfg_data[MS_W-1:0];
        gntl_pkg::REG_MIN_OBSERVATIONS: min_observations <= cfg_data[gntl_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // lifecycle state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v         <= 1'b0;
      old_count    <= '0;
      new_count    <= '0;
      bank         <= 1'b0;
      next_ident   <= ID_W'(1);
      frame_number <= ID_W'(1);
      out_valid    <= 1'b0;
      found        <= 1'b0;
      scan_i       <= '0;
      dropped      <= '0;
    end else begin
      rd_v   <= rd_en && (st != gntl_pkg::ST_OBS_READ);
      rd_idx <= scan_i[IW-1:0];
      if (rd_en && (st != gntl_pkg::ST_OBS_READ)) scan_i <= scan_i + 1'b1;

      if (in_valid && in_ready) begin
        op_eof  <= op;
        ox      <= center_x;
        oy      <= center_y;
        oz      <= center_z;
        gate_sq <= gate_dist * gate_dist;
        found   <= 1'b0;
        scan_i  <= '0;
        dropped <= '0;
      end

      // best candidate, ties keep the lower position (earlier arrival)
      if (d_out.vld && d_out.ok && (!found || d_dist < best_dist)) begin
        found     <= 1'b1;
        best_idx  <= d_idx;
        best_dist <= d_dist;
      end

      if (st == gntl_pkg::ST_OBS_DRAIN && drain_done && !found) begin
        res_id     <= next_ident;
        res_first  <= frame_number;
        res_age    <= AGE_W'(1);
        next_ident <= next_ident + 1'b1;
      end
      if (st == gntl_pkg::ST_OBS_FETCH) begin
        hold_rec  <= rdata;
        res_id    <= r_id;
        res_first <= r_first;
        res_age   <= (r_age == '1) ? r_age : r_age + 1'b1;
      end
      // full is taken before the new entry bumps the count
      if (st == gntl_pkg::ST_OBS_STORE) begin
        res_full <= full;
        if (!full) new_count <= new_count + 1'b1;
      end

      if (eof_keep) new_count <= new_count + 1'b1;
      if (eof_drop) dropped   <= dropped + 1'b1;

      if (out_load) begin
        out_valid <= 1'b1;
        if (op_eof) begin
          bank         <= !bank;
          old_count    <= new_count;
          new_count    <= '0;
          frame_number <= frame_number + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      cluster_id       <= op_eof ? '0 : res_id;
      cluster_age      <= op_eof ? '0 : res_age;
      cluster_status   <= !op_eof && (res_age >= AGE_W'(thr));
      first_seen_frame <= op_eof ? '0 : res_first;
      was_matched      <= !op_eof && found;
      table_full       <= !op_eof && res_full;
      tracked_count    <= op_eof ? new_count : '0;
      dropped_count    <= op_eof ? dropped : '0;
    end
  end

endmodule

// ===== hdl/gntl_checker.sv =====
// Port-level checker for the track association block, with its bind.
module gntl_checker #(
  parameter int MAX_TRACKED = gntl_pkg::DEF_MAX_TRACKED,
  localparam int CW         = $clog2(MAX_TRACKED + 1)
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gntl_pkg::ID_W-1:0]      cluster_id,
  input logic [gntl_pkg::AGE_W-1:0]     cluster_age,
  input logic                           was_matched,
  input logic [CW-1:0]                  tracked_count,
  input logic [CW-1:0]                  dropped_count
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cluster_id) && $stable(tracked_count))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_matched_age: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_matched |-> cluster_age >= gntl_pkg::AGE_W'(2) && cluster_id != '0)
    else $error("matched result with fresh age");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tracked_count <= CW'(MAX_TRACKED) &&
                  (tracked_count == '0 && dropped_count == '0 || cluster_id == '0))
    else $error("frame counts out of range or mixed with observation");

endmodule

bind gated_nearest_track_lifecycle gntl_checker #(
  .MAX_TRACKED (MAX_TRACKED)
) u_gntl_checker (.*);
